### rtl/tcis_pkg.sv
// shared types and constants for the teaching cpu step block
package tcis_pkg;

   localparam int MEM_DEPTH  = 256;
   localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);
   localparam int REG_COUNT  = 16;
   localparam int REG_IDX_W  = $clog2(REG_COUNT);

   // opcodes
   localparam logic [3:0] OP_LOAD_MEM = 4'h1;
   localparam logic [3:0] OP_LOAD_IMM = 4'h2;
   localparam logic [3:0] OP_STORE    = 4'h3;
   localparam logic [3:0] OP_MOVE     = 4'h4;
   localparam logic [3:0] OP_ADD_INT  = 4'h5;
   localparam logic [3:0] OP_ADD_FP   = 4'h6;
   localparam logic [3:0] OP_JUMP_EQ  = 4'hB;
   localparam logic [3:0] OP_HALT     = 4'hC;

   // 8-bit float: sign, bias-3 exponent, mantissa below an implicit one
   typedef struct packed {
      logic       sign;
      logic [2:0] expo;
      logic [3:0] mant;
   } fp8_type;

endpackage

### rtl/tcis_fpadd.sv
// 8-bit float adder, exact in 2^-7 fixed point, truncating renormalize
module tcis_fpadd import tcis_pkg::*; (
   input  fp8_type a,
   input  fp8_type b,
   output fp8_type sum
);

   logic [11:0]        mag_a;
   logic [11:0]        mag_b;
   logic signed [13:0] val_a;
   logic signed [13:0] val_b;
   logic signed [13:0] total;
   logic [12:0]        mag;
   logic [3:0]         lead;
   logic [3:0]         shamt;
   logic [12:0]        shifted;

   always_comb begin
      mag_a = 12'({1'b1, a.mant}) << a.expo;
      mag_b = 12'({1'b1, b.mant}) << b.expo;
      val_a = a.sign ? -$signed({2'b00, mag_a}) : $signed({2'b00, mag_a});
      val_b = b.sign ? -$signed({2'b00, mag_b}) : $signed({2'b00, mag_b});
      total = val_a + val_b;
      mag   = total[13] ? 13'(-total) : total[12:0];
      // leading one, only bits 4 and up matter
      lead = 4'd4;
      for (int i = 5; i < 13; i++) begin
         if (mag[i]) begin
            lead = 4'(i);
         end
      end
      shamt   = lead - 4'd4;
      shifted = mag >> shamt;
      if (mag[12:4] == '0) begin
         sum = '0;
      end else begin
         sum.sign = total[13];
         sum.expo = shamt[3] ? 3'd7 : shamt[2:0];
         sum.mant = shifted[3:0];
      end
   end

endmodule

### rtl/teaching_cpu_instruction_step_top.sv
// flow: a word goes through the fetch stage, execute stage and output register;
//    loads and steps alike wait while one is in fetch (both instruction bytes are
//    fetched in the accept cycle, operands read in the next cycle) or while a full
//    output register stalls execute; all memory and register writes happen in execute
// reset: clears pc, halt flag and the valid bits of memory and registers, so
//    unwritten bytes and registers read as zero; no clearing pass is needed
module teaching_cpu_instruction_step_top import tcis_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_load_address,
   input  logic [7:0]  req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pc_after,
   output logic [15:0] rsp_instruction_word,
   output logic        rsp_halted,
   output logic        rsp_unknown_opcode,
   output logic        rsp_reg_write,
   output logic [3:0]  rsp_reg_index,
   output logic [7:0]  rsp_reg_value,
   output logic        rsp_mem_write,
   output logic [7:0]  rsp_mem_address,
   output logic [7:0]  rsp_mem_value
);

   // main memory and its valid bits
   logic [7:0]            mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]  mem_vld_ff;
   logic [7:0]            mem_rd_a_ff;
   logic [7:0]            mem_rd_b_ff;
   logic                  mem_vld_a_ff;
   logic                  mem_vld_b_ff;
   logic [MEM_ADDR_W-1:0] mem_addr_a;
   logic [MEM_ADDR_W-1:0] mem_addr_b;
   logic                  mem_rd_a_en;
   logic                  mem_we;
   logic [MEM_ADDR_W-1:0] mem_waddr;
   logic [7:0]            mem_wdata;

   // register file and its valid bits
   logic [7:0]           rf_ff [REG_COUNT];
   logic [REG_COUNT-1:0] rf_vld_ff;
   logic [7:0]           rf_rd_a_ff;
   logic [7:0]           rf_rd_b_ff;
   logic                 rf_vld_a_ff;
   logic                 rf_vld_b_ff;
   logic [REG_IDX_W-1:0] rf_addr_a;
   logic [REG_IDX_W-1:0] rf_addr_b;
   logic                 rf_we;

   // architectural state
   logic [7:0] pc_ff, pc_in;
   logic       halted_ff, halted_in;

   // stage 1: fetch data arriving
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_kind_ff;
   logic [7:0] s1_load_addr_ff;
   logic [7:0] s1_load_data_ff;
   logic       byp0_ff, byp0_in;
   logic       byp1_ff, byp1_in;
   logic [7:0] byp_data_ff;
   logic [15:0] s1_word;
   logic [3:0]  s1_op;

   // stage 2: execute
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_kind_ff;
   logic [15:0] s2_word_ff;
   logic [7:0]  s2_load_addr_ff;
   logic [7:0]  s2_load_data_ff;
   logic        s2_adv;

   logic        accept;
   logic [7:0]  fetch_pc;
   logic [7:0]  fetch_pc1;

   // execute results
   logic [3:0] op;
   logic [3:0] fld_r;
   logic [3:0] fld_s;
   logic [3:0] fld_t;
   logic [7:0] fld_xy;
   logic [7:0] byte_xy;
   logic [7:0] opnd_a;
   logic [7:0] opnd_b;
   fp8_type    fp_sum;
   logic       ex_unknown;
   logic       ex_rw;
   logic [3:0] ex_ridx;
   logic [7:0] ex_rval;
   logic       ex_mw;
   logic [7:0] ex_maddr;
   logic [7:0] ex_mval;
   logic       ex_halt;
   logic [7:0] ex_next_pc;

   // output register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_pc_after_ff;
   logic [15:0] rsp_word_ff;
   logic        rsp_halted_ff;
   logic        rsp_unknown_ff;
   logic        rsp_rw_ff;
   logic [3:0]  rsp_ridx_ff;
   logic [7:0]  rsp_rval_ff;
   logic        rsp_mw_ff;
   logic [7:0]  rsp_maddr_ff;
   logic [7:0]  rsp_mval_ff;

   // handshake and stage flow
   assign s2_adv    = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign accept    = req_valid && req_ready;

   // execute stage
   assign op      = s2_word_ff[15:12];
   assign fld_r   = s2_word_ff[11:8];
   assign fld_s   = s2_word_ff[7:4];
   assign fld_t   = s2_word_ff[3:0];
   assign fld_xy  = s2_word_ff[7:0];
   assign byte_xy = mem_vld_a_ff ? mem_rd_a_ff : '0;
   assign opnd_a  = rf_vld_a_ff ? rf_rd_a_ff : '0;
   assign opnd_b  = rf_vld_b_ff ? rf_rd_b_ff : '0;

   tcis_fpadd u_fpadd (
      .a   (fp8_type'(opnd_a)),
      .b   (fp8_type'(opnd_b)),
      .sum (fp_sum)
   );

   always_comb begin
      ex_unknown = 1'b0;
      ex_rw      = 1'b0;
      ex_ridx    = '0;
      ex_rval    = '0;
      ex_mw      = 1'b0;
      ex_maddr   = '0;
      ex_mval    = '0;
      ex_halt    = 1'b0;
      ex_next_pc = pc_ff;
      if (s2_kind_ff) begin
         ex_next_pc = pc_ff + 8'd2;
         case (op)
            OP_LOAD_MEM: begin
               ex_rw   = 1'b1;
               ex_ridx = fld_r;
               ex_rval = byte_xy;
            end
            OP_LOAD_IMM: begin
               ex_rw   = 1'b1;
               ex_ridx = fld_r;
               ex_rval = fld_xy;
            end
            OP_STORE: begin
               ex_mw    = 1'b1;
               ex_maddr = fld_xy;
               ex_mval  = opnd_a;
            end
            OP_MOVE: begin
               ex_rw   = 1'b1;
               ex_ridx = fld_t;
               ex_rval = opnd_a;
            end
            OP_ADD_INT: begin
               ex_rw   = 1'b1;
               ex_ridx = fld_r;
               ex_rval = opnd_a + opnd_b;
            end
            OP_ADD_FP: begin
               ex_rw   = 1'b1;
               ex_ridx = fld_r;
               ex_rval = fp_sum;
            end
            OP_JUMP_EQ: begin
               if (opnd_a == opnd_b) begin
                  ex_next_pc = fld_xy;
               end
            end
            OP_HALT: begin
               ex_halt = 1'b1;
            end
            default: begin
               ex_unknown = 1'b1;
            end
         endcase
      end
   end

   // every memory write happens as the execute stage retires
   assign mem_we    = s2_adv && (s2_kind_ff ? ex_mw : 1'b1);
   assign mem_waddr = s2_kind_ff ? ex_maddr : s2_load_addr_ff;
   assign mem_wdata = s2_kind_ff ? ex_mval : s2_load_data_ff;
   assign rf_we     = s2_adv && ex_rw;

   assign pc_in     = s2_adv ? ex_next_pc : pc_ff;
   assign halted_in = halted_ff || (s2_adv && ex_halt);

   // a fetch in the same cycle as a retire uses the retiring pc
   assign fetch_pc  = s2_valid_ff ? ex_next_pc : pc_ff;
   assign fetch_pc1 = fetch_pc + 8'd1;

   // bytes written at the fetch edge would be read stale
   assign byp0_in = mem_we && (mem_waddr == fetch_pc);
   assign byp1_in = mem_we && (mem_waddr == fetch_pc1);

   // stage 1 decode of the fetched word and operand reads
   always_comb begin
      s1_word[15:8] = byp0_ff ? byp_data_ff : (mem_vld_a_ff ? mem_rd_a_ff : '0);
      s1_word[7:0]  = byp1_ff ? byp_data_ff : (mem_vld_b_ff ? mem_rd_b_ff : '0);
      s1_op         = s1_word[15:12];
      if (s1_op == OP_STORE || s1_op == OP_JUMP_EQ) begin
         rf_addr_a = s1_word[11:8];
      end else begin
         rf_addr_a = s1_word[7:4];
      end
      rf_addr_b = (s1_op == OP_JUMP_EQ) ? '0 : s1_word[3:0];
   end

   assign mem_rd_a_en = accept || s1_valid_ff;
   assign mem_addr_a  = accept ? fetch_pc : s1_word[7:0];
   assign mem_addr_b  = fetch_pc1;

   assign s1_valid_in = accept;
   assign s2_valid_in = s1_valid_ff || (s2_valid_ff && !s2_adv);

   // main memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_rd_a_en) begin
         mem_rd_a_ff  <= mem_ff[mem_addr_a];
         mem_vld_a_ff <= mem_vld_ff[mem_addr_a];
      end
      if (accept) begin
         mem_rd_b_ff  <= mem_ff[mem_addr_b];
         mem_vld_b_ff <= mem_vld_ff[mem_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
      end else if (mem_we) begin
         mem_vld_ff[mem_waddr] <= 1'b1;
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_ff[ex_ridx] <= ex_rval;
      end
      if (s1_valid_ff) begin
         rf_rd_a_ff  <= rf_ff[rf_addr_a];
         rf_rd_b_ff  <= rf_ff[rf_addr_b];
         rf_vld_a_ff <= rf_vld_ff[rf_addr_a];
         rf_vld_b_ff <= rf_vld_ff[rf_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (rf_we) begin
         rf_vld_ff[ex_ridx] <= 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff       <= pc_in;
         halted_ff   <= halted_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s2_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff      <= req_kind;
         s1_load_addr_ff <= req_load_address;
         s1_load_data_ff <= req_load_data;
         byp0_ff         <= byp0_in;
         byp1_ff         <= byp1_in;
         byp_data_ff     <= mem_wdata;
      end
      if (s1_valid_ff) begin
         s2_kind_ff      <= s1_kind_ff;
         s2_word_ff      <= s1_kind_ff ? s1_word : '0;
         s2_load_addr_ff <= s1_load_addr_ff;
         s2_load_data_ff <= s1_load_data_ff;
      end
      if (s2_adv) begin
         rsp_pc_after_ff <= ex_next_pc;
         rsp_word_ff     <= s2_word_ff;
         rsp_halted_ff   <= halted_in;
         rsp_unknown_ff  <= ex_unknown;
         rsp_rw_ff       <= ex_rw;
         rsp_ridx_ff     <= ex_ridx;
         rsp_rval_ff     <= ex_rval;
         rsp_mw_ff       <= ex_mw;
         rsp_maddr_ff    <= ex_maddr;
         rsp_mval_ff     <= ex_mval;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pc_after         = rsp_pc_after_ff;
   assign rsp_instruction_word = rsp_word_ff;
   assign rsp_halted           = rsp_halted_ff;
   assign rsp_unknown_opcode   = rsp_unknown_ff;
   assign rsp_reg_write        = rsp_rw_ff;
   assign rsp_reg_index        = rsp_ridx_ff;
   assign rsp_reg_value        = rsp_rval_ff;
   assign rsp_mem_write        = rsp_mw_ff;
   assign rsp_mem_address      = rsp_maddr_ff;
   assign rsp_mem_value        = rsp_mval_ff;

`ifndef NO_ASSERTIONS
   // decode always moves straight into execute
   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> s2_valid_ff)
      else $error("decode word did not reach execute");

   // execute is empty while decode holds a word, so operand reads see all writes
   a_s1_s2_excl: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !s2_valid_ff)
      else $error("decode and execute occupied together");

   // one retiring word never writes both memory and a register
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && rf_we))
      else $error("memory and register written by one word");

   // halt flag is sticky
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(halted_ff))
      else $error("halt flag cleared outside reset");

   // a word is retired only with room in the output register
   a_retire_room: assert property (@(posedge clock) disable iff (reset)
      s2_adv |=> rsp_valid_ff)
      else $error("retired word not presented");
`endif

endmodule

### sim/tb_teaching_cpu_instruction_step_top.sv
// testbench for the teaching cpu step block: random programs checked against a local cpu image
module tb_teaching_cpu_instruction_step_top import tcis_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic       kind;
      logic [7:0] address;
      logic [7:0] data;
   } cpu_request_type;

   typedef struct {
      logic [7:0]  pc_after;
      logic [15:0] instruction_word;
      logic        halted;
      logic        unknown_opcode;
      logic        reg_write;
      logic [3:0]  reg_index;
      logic [7:0]  reg_value;
      logic        mem_write;
      logic [7:0]  mem_address;
      logic [7:0]  mem_value;
   } step_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [7:0]  req_load_address = 8'h00;
   logic [7:0]  req_load_data = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_pc_after;
   logic [15:0] rsp_instruction_word;
   logic        rsp_halted;
   logic        rsp_unknown_opcode;
   logic        rsp_reg_write;
   logic [3:0]  rsp_reg_index;
   logic [7:0]  rsp_reg_value;
   logic        rsp_mem_write;
   logic [7:0]  rsp_mem_address;
   logic [7:0]  rsp_mem_value;

   // cpu image kept in step with every accepted word
   logic [7:0] mem_image [MEM_DEPTH];
   logic [7:0] reg_image [REG_COUNT];
   logic [7:0] pc_image = 8'h00;
   logic       halt_image = 1'b0;

   cpu_request_type cpu_requests [$];
   step_result_type step_results [$];
   cpu_request_type taken_request;
   cpu_request_type next_request;
   step_result_type predicted;
   step_result_type want;

   int error_count = 0;
   int items_queued = 0;
   int items_accepted = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_cycles = 0;
   logic hold_off = 1'b0;
   logic hold_done = 1'b0;

   localparam logic [3:0] KNOWN_OPS [8] = '{OP_LOAD_MEM, OP_LOAD_IMM, OP_STORE, OP_MOVE,
                                             OP_ADD_INT, OP_ADD_FP, OP_JUMP_EQ, OP_HALT};

   teaching_cpu_instruction_step_top DUT (.*);

   always #5 clock = ~clock;

   initial begin
      foreach (mem_image[i]) mem_image[i] = 8'h00;
      foreach (reg_image[i]) reg_image[i] = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // exact sum in 2^-7 units, renormalized with truncation
   function automatic logic [7:0] float_sum(fp8_type a, fp8_type b);
      int va, vb, total, mag, p, ex;
      fp8_type res;
      va = (16 + a.mant) << a.expo;
      vb = (16 + b.mant) << b.expo;
      if (a.sign) va = -va;
      if (b.sign) vb = -vb;
      total = va + vb;
      mag = (total < 0) ? -total : total;
      if (mag < 16) return 8'h00;
      p = 4;
      while (p < 31 && (mag >> (p + 1)) != 0) p++;
      ex = p - 4;
      if (ex > 7) ex = 7;
      res.sign = (total < 0);
      res.expo = ex[2:0];
      res.mant = 4'(mag >> (p - 4));
      return res;
   endfunction

   function automatic step_result_type execute_step(cpu_request_type rq);
      step_result_type res;
      logic [15:0] word;
      logic [7:0] second, xy, next_pc;
      logic [3:0] op, r, s, t;
      res = '{default: '0};
      if (!rq.kind) begin
         mem_image[rq.address] = rq.data;
      end else begin
         second = pc_image + 8'd1;
         word = {mem_image[pc_image], mem_image[second]};
         {op, r, s, t} = word;
         xy = word[7:0];
         next_pc = pc_image + 8'd2;
         res.instruction_word = word;
         case (op)
            OP_LOAD_MEM: begin
               res.reg_write = 1'b1; res.reg_index = r; res.reg_value = mem_image[xy];
            end
            OP_LOAD_IMM: begin
               res.reg_write = 1'b1; res.reg_index = r; res.reg_value = xy;
            end
            OP_STORE: begin
               res.mem_write = 1'b1; res.mem_address = xy; res.mem_value = reg_image[r];
            end
            OP_MOVE: begin
               res.reg_write = 1'b1; res.reg_index = t; res.reg_value = reg_image[s];
            end
            OP_ADD_INT: begin
               res.reg_write = 1'b1; res.reg_index = r;
               res.reg_value = reg_image[s] + reg_image[t];
            end
            OP_ADD_FP: begin
               res.reg_write = 1'b1; res.reg_index = r;
               res.reg_value = float_sum(reg_image[s], reg_image[t]);
            end
            OP_JUMP_EQ: begin
               if (reg_image[r] == reg_image[0]) next_pc = xy;
            end
            OP_HALT: halt_image = 1'b1;
            default: res.unknown_opcode = 1'b1;
         endcase
         if (res.reg_write) reg_image[res.reg_index] = res.reg_value;
         if (res.mem_write) mem_image[res.mem_address] = res.mem_value;
         pc_image = next_pc;
      end
      res.pc_after = pc_image;
      res.halted = halt_image;
      return res;
   endfunction

   function automatic void check_field(string name, logic [15:0] expected, logic [15:0] actual);
      if (expected !== actual) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
         error_count++;
      end
   endfunction

   // mostly back to back, some short gaps, a few long ones, and stretches with no gaps at all
   function automatic int random_gap();
      int pick;
      if (((cycle_count >> 8) % 4) == 3) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [3:0] random_reg();
      return $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
   endfunction

   // float and wrap corners show up more often than plain random bytes
   function automatic logic [7:0] random_operand();
      logic [7:0] corners [8] = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h0F, 8'hF0, 8'h10, 8'h90};
      return $urandom_range(0, 1) ? corners[$urandom_range(0, 7)] : 8'($urandom);
   endfunction

   function automatic logic [15:0] random_instruction(logic [7:0] base, int span);
      logic [3:0] op;
      logic [7:0] xy;
      if ($urandom_range(0, 99) < 8) begin
         do op = 4'($urandom_range(0, 15)); while (op inside {KNOWN_OPS});
      end else begin
         op = KNOWN_OPS[$urandom_range(0, 7)];
      end
      case (op)
         OP_LOAD_IMM: xy = random_operand();
         OP_MOVE, OP_ADD_INT, OP_ADD_FP: xy = {random_reg(), random_reg()};
         OP_JUMP_EQ: begin
            // jumps mostly land on an instruction of the same program
            if ($urandom_range(0, 4) == 0) xy = 8'($urandom);
            else xy = 8'(base + 2 * $urandom_range(0, span));
         end
         default: xy = 8'($urandom);
      endcase
      return {op, random_reg(), xy};
   endfunction

   task automatic push_byte(logic [7:0] address, logic [7:0] data);
      cpu_request_type rq;
      rq.kind = 1'b0;
      rq.address = address;
      rq.data = data;
      cpu_requests.insert(cpu_requests.size(), rq);
      items_queued++;
   endtask

   task automatic push_step();
      cpu_request_type rq;
      rq.kind = 1'b1;
      rq.address = 8'($urandom);
      rq.data = 8'($urandom);
      cpu_requests.insert(cpu_requests.size(), rq);
      items_queued++;
   endtask

   task automatic wait_drained();
      while (cpu_requests.size() != 0 || step_results.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            taken_request.kind = req_kind;
            taken_request.address = req_load_address;
            taken_request.data = req_load_data;
            predicted = execute_step(taken_request);
            step_results.insert(step_results.size(), predicted);
            items_accepted <= items_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (cpu_requests.size() > 0) begin
               next_request = cpu_requests.pop_front();
               req_kind <= next_request.kind;
               req_load_address <= next_request.address;
               req_load_data <= next_request.data;
               req_valid <= 1'b1;
               send_gap = random_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off while words are still queued
   always @(posedge clock) begin
      if (reset) begin
         hold_off <= 1'b0;
         hold_cycles <= 0;
         hold_done <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (!hold_done && (hold_off || (items_accepted >= 500 && cpu_requests.size() >= 6))) begin
            if (hold_cycles == 150) begin
               hold_off <= 1'b0;
               hold_done <= 1'b1;
            end else begin
               hold_off <= 1'b1;
               hold_cycles <= hold_cycles + 1;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (step_results.size() == 0) begin
               $error("result word with no step outstanding");
               error_count++;
            end else begin
               want = step_results.pop_front();
               check_field("pc_after", want.pc_after, rsp_pc_after);
               check_field("instruction_word", want.instruction_word, rsp_instruction_word);
               check_field("halted", want.halted, rsp_halted);
               check_field("unknown_opcode", want.unknown_opcode, rsp_unknown_opcode);
               check_field("reg_write", want.reg_write, rsp_reg_write);
               check_field("reg_index", want.reg_index, rsp_reg_index);
               check_field("reg_value", want.reg_value, rsp_reg_value);
               check_field("mem_write", want.mem_write, rsp_mem_write);
               check_field("mem_address", want.mem_address, rsp_mem_address);
               check_field("mem_value", want.mem_value, rsp_mem_value);
            end
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap = random_gap();
         end
      end
   end

   initial begin
      logic [15:0] intro [9];
      logic [15:0] word;
      logic [7:0] base;
      int span;
      intro = '{{OP_LOAD_IMM, 4'd0, 8'h7F},
                {OP_LOAD_IMM, 4'd1, 8'hFF},
                {OP_ADD_INT, 4'd5, 4'd0, 4'd1},    // wraps past 255
                {OP_ADD_FP, 4'd6, 4'd0, 4'd0},     // exponent saturates
                {OP_ADD_FP, 4'd4, 4'd0, 4'd1},     // cancels to zero
                {OP_STORE, 4'd1, 8'hFF},
                {OP_MOVE, 4'd0, 4'd1, 4'd15},
                {OP_HALT, 12'h000},
                {OP_JUMP_EQ, 4'd0, 8'hFF}};        // taken, lands on the top byte
      foreach (intro[k]) begin
         push_byte(8'(2 * k), intro[k][15:8]);
         push_byte(8'(2 * k + 1), intro[k][7:0]);
      end
      // two more steps: fetch wrapping past the top, then a step while halted
      repeat (11) push_step();

      while (items_queued < 1100) begin
         if ($urandom_range(0, 99) < 80) begin
            wait_drained();
            base = pc_image;
            span = $urandom_range(1, 8);
            for (int k = 0; k < span; k++) begin
               word = random_instruction(base, span);
               // now and then a byte goes missing to break the program
               if ($urandom_range(0, 19) != 0) push_byte(8'(base + 2 * k), word[15:8]);
               if ($urandom_range(0, 19) != 0) push_byte(8'(base + 2 * k + 1), word[7:0]);
            end
            repeat (span + $urandom_range(0, 3)) push_step();
         end else begin
            @(negedge clock);
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 8'($urandom));
            repeat ($urandom_range(1, 4)) push_step();
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (error_count == 0 && step_results.size() == 0)
         $display("tb_teaching_cpu_instruction_step_top: done, clean");
      else
         $display("tb_teaching_cpu_instruction_step_top: done, errors");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("tb_teaching_cpu_instruction_step_top: done, errors");
      $finish;
   end

endmodule

### teaching_cpu_instruction_step_top.f
rtl/tcis_pkg.sv
rtl/tcis_fpadd.sv
rtl/teaching_cpu_instruction_step_top.sv
sim/tb_teaching_cpu_instruction_step_top.sv
